// ===== rtl/ihft_pkg.sv =====
`timescale 1ns / 1ps

package ihft_pkg;

    localparam int NUM_BUTTONS    = 32;
    localparam int NUM_AXES       = 8;
    localparam int NUM_PADS       = 2;
    localparam int NUM_DIRECTIONS = 4;
    localparam int COUNT_WIDTH    = 16;

    localparam int OP_W     = 4;
    localparam int ID_W     = 5;
    localparam int PAD_W    = 1;
    localparam int LEVEL_W  = 16;

    localparam int DIR_BASE  = NUM_BUTTONS;
    localparam int AXIS_BASE = NUM_BUTTONS + NUM_PADS * NUM_DIRECTIONS;
    localparam int NUM_CELLS = AXIS_BASE + NUM_AXES;
    localparam int STEP_W    = $clog2(NUM_CELLS + 1);

    typedef logic signed [COUNT_WIDTH-1:0] t_count;
    typedef logic signed [LEVEL_W-1:0]     t_level;

    localparam t_count CNT_ONE     = t_count'(1);
    localparam t_count CNT_NEG_ONE = t_count'(-1);
    localparam t_count CNT_MAX     = t_count'((64'd1 << (COUNT_WIDTH - 1)) - 64'd1);
    localparam t_count CNT_MIN     = t_count'(-((64'sd1 <<< (COUNT_WIDTH - 1)) - 64'sd1));

    localparam logic [OP_W-1:0] OP_BTN_PRESS   = 4'd0;
    localparam logic [OP_W-1:0] OP_BTN_RELEASE = 4'd1;
    localparam logic [OP_W-1:0] OP_DIR_PRESS   = 4'd2;
    localparam logic [OP_W-1:0] OP_DIR_RELEASE = 4'd3;
    localparam logic [OP_W-1:0] OP_AXIS_SAMPLE = 4'd4;
    localparam logic [OP_W-1:0] OP_FRAME_TICK  = 4'd5;
    localparam logic [OP_W-1:0] OP_READ_BTN    = 4'd6;
    localparam logic [OP_W-1:0] OP_READ_DIR    = 4'd7;
    localparam logic [OP_W-1:0] OP_READ_AXIS   = 4'd8;

    typedef struct packed {
        logic   go;
        logic   set_pos;
        logic   set_neg;
        logic   sample;
        logic   tick;
        logic   above;
        logic   below;
        t_level level;
    } t_cmd;

    typedef struct packed {
        t_count count;
        t_level level;
        logic   evt_dn;
        logic   evt_up;
    } t_link;

endpackage

// ===== rtl/ihft_cell.sv =====
`timescale 1ns / 1ps

module ihft_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ihft_pkg::t_cmd  i_cmd,
    input  logic           i_hit,
    input  logic           i_sel_cnt,
    input  logic           i_sel_lvl,
    input  ihft_pkg::t_link i_link,
    output ihft_pkg::t_link o_link
);

    ihft_pkg::t_count r_count;
    ihft_pkg::t_count n_count;
    ihft_pkg::t_level r_level;
    ihft_pkg::t_level n_level;
    logic             r_dn;
    logic             n_dn;
    logic             r_up;
    logic             n_up;
    ihft_pkg::t_link  r_link;
    ihft_pkg::t_link  n_link;

    always_comb begin
        n_count = r_count;
        n_level = r_level;
        n_dn    = r_dn;
        n_up    = r_up;
        if (i_cmd.go) begin
            n_dn = 1'b0;
            n_up = 1'b0;
            if (i_cmd.tick) begin
                if (r_count > 0 && r_count != ihft_pkg::CNT_MAX) begin
                    n_count = r_count + ihft_pkg::CNT_ONE;
                end else if (r_count < 0 && r_count != ihft_pkg::CNT_MIN) begin
                    n_count = r_count - ihft_pkg::CNT_ONE;
                end
            end else if (i_hit) begin
                if (i_cmd.set_pos) begin
                    n_count = ihft_pkg::CNT_ONE;
                end else if (i_cmd.set_neg) begin
                    n_count = ihft_pkg::CNT_NEG_ONE;
                end else if (i_cmd.sample) begin
                    n_level = i_cmd.level;
                    if (i_cmd.above && r_count <= 0) begin
                        n_count = ihft_pkg::CNT_ONE;
                        n_dn    = 1'b1;
                    end else if (i_cmd.below && r_count > 0) begin
                        n_count = ihft_pkg::CNT_NEG_ONE;
                        n_up    = 1'b1;
                    end
                end
            end
        end
    end

    // pass the neighbor's value on unless this cell is the one addressed
    always_comb begin
        n_link = i_link;
        if (i_sel_cnt) begin
            n_link.count = r_count;
        end
        if (i_sel_lvl) begin
            n_link.level  = r_level;
            n_link.evt_dn = r_dn;
            n_link.evt_up = r_up;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_level <= '0;
            r_dn    <= 1'b0;
            r_up    <= 1'b0;
        end else begin
            r_count <= n_count;
            r_level <= n_level;
            r_dn    <= n_dn;
            r_up    <= n_up;
        end
    end

    always_ff @(posedge i_clk) begin
        r_link <= n_link;
    end

    assign o_link = r_link;

endmodule

// ===== rtl/input_hold_frame_tracker_unit.sv =====
`timescale 1ns / 1ps

// Hold-frame tracker for buttons, d-pad directions and analog axes. A request is
// taken only while the block is idle. Its result is built in an update state
// in which all 48 counter cells update together (a frame tick advances every count
// at once), then a run state in which the addressed count and axis level travel
// down the registered chain of cells, and then a load into the output register.
// The next request can be taken in the cycle after that load. The result
// register is separate from the request side; a result that is not taken holds
// the block until the output register frees up. Threshold writes take effect at
// once and are meant to happen while the block is idle.
module input_hold_frame_tracker_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic signed [ihft_pkg::LEVEL_W-1:0]  i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [ihft_pkg::OP_W-1:0]            i_op,
    input  logic [ihft_pkg::ID_W-1:0]            i_entry_id,
    input  logic [ihft_pkg::PAD_W-1:0]           i_pad_select,
    input  logic signed [ihft_pkg::LEVEL_W-1:0]  i_axis_sample,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [ihft_pkg::COUNT_WIDTH-1:0] o_frame_count,
    output logic signed [ihft_pkg::LEVEL_W-1:0]  o_axis_level,
    output logic signed [5:0]                    o_last_button_down,
    output logic signed [5:0]                    o_last_button_up,
    output logic signed [3:0]                    o_last_axis_down,
    output logic signed [3:0]                    o_last_axis_up,
    output logic signed [2:0]                    o_last_dir_down,
    output logic                                 o_last_dir_down_pad,
    output logic signed [2:0]                    o_last_dir_up,
    output logic                                 o_last_dir_up_pad
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_UPD  = 2'd1;
    localparam logic [1:0] ST_RUN  = 2'd2;

    logic [1:0]                    r_state;
    logic [1:0]                    n_state;
    logic [ihft_pkg::STEP_W-1:0]   r_step;
    logic [ihft_pkg::STEP_W-1:0]   n_step;
    ihft_pkg::t_level              r_threshold;

    logic [ihft_pkg::OP_W-1:0]     r_op;
    logic [ihft_pkg::ID_W-1:0]     r_id;
    logic [ihft_pkg::PAD_W-1:0]    r_pad;
    ihft_pkg::t_level              r_sample;

    ihft_pkg::t_count              r_frame_count;
    ihft_pkg::t_level              r_axis_level;
    logic                          r_out_valid;
    logic                          n_out_valid;

    logic signed [5:0]             r_btn_dn, n_btn_dn, r_btn_up, n_btn_up;
    logic signed [3:0]             r_axis_dn, n_axis_dn, r_axis_up, n_axis_up;
    logic signed [2:0]             r_dir_dn, n_dir_dn, r_dir_up, n_dir_up;
    logic                          r_dir_dn_pad, n_dir_dn_pad, r_dir_up_pad, n_dir_up_pad;

    logic                          w_accept;
    logic                          w_load;
    logic                          w_btn_wr, w_btn_rd, w_dir_wr, w_dir_rd, w_axis_rd;
    logic                          w_btn_ok, w_dir_ok;
    ihft_pkg::t_cmd                w_cmd;
    logic [ihft_pkg::NUM_CELLS-1:0] w_hit;
    logic [ihft_pkg::NUM_CELLS-1:0] w_sel_cnt;
    logic [ihft_pkg::NUM_CELLS-1:0] w_sel_lvl;
    ihft_pkg::t_link               w_link [0:ihft_pkg::NUM_CELLS];

    assign w_accept = i_in_valid && o_in_ready;
    assign w_load   = (r_state == ST_RUN) && (r_step == ihft_pkg::STEP_W'(ihft_pkg::NUM_CELLS))
                      && (!r_out_valid || i_out_ready);

    assign w_btn_wr  = (r_op == ihft_pkg::OP_BTN_PRESS) || (r_op == ihft_pkg::OP_BTN_RELEASE);
    assign w_btn_rd  = w_btn_wr || (r_op == ihft_pkg::OP_READ_BTN);
    assign w_dir_wr  = (r_op == ihft_pkg::OP_DIR_PRESS) || (r_op == ihft_pkg::OP_DIR_RELEASE);
    assign w_dir_rd  = w_dir_wr || (r_op == ihft_pkg::OP_READ_DIR);
    assign w_axis_rd = (r_op == ihft_pkg::OP_AXIS_SAMPLE) || (r_op == ihft_pkg::OP_READ_AXIS);
    assign w_btn_ok  = int'(r_id) < ihft_pkg::NUM_BUTTONS;
    assign w_dir_ok  = (int'(r_id) < ihft_pkg::NUM_DIRECTIONS)
                       && (int'(r_pad) < ihft_pkg::NUM_PADS);

    always_comb begin
        w_cmd         = '0;
        w_cmd.go      = (r_state == ST_UPD);
        w_cmd.set_pos = (r_op == ihft_pkg::OP_BTN_PRESS) || (r_op == ihft_pkg::OP_DIR_PRESS);
        w_cmd.set_neg = (r_op == ihft_pkg::OP_BTN_RELEASE)
                        || (r_op == ihft_pkg::OP_DIR_RELEASE);
        w_cmd.sample  = (r_op == ihft_pkg::OP_AXIS_SAMPLE);
        w_cmd.tick    = (r_op == ihft_pkg::OP_FRAME_TICK);
        w_cmd.above   = r_sample > r_threshold;
        w_cmd.below   = r_sample < r_threshold;
        w_cmd.level   = r_sample;
    end

    assign w_link[0] = '0;

    genvar gb, gp, gd, ga;
    generate
        for (gb = 0; gb < ihft_pkg::NUM_BUTTONS; gb++) begin : g_btn
            assign w_hit[gb]     = w_btn_wr && (int'(r_id) == gb);
            assign w_sel_cnt[gb] = w_btn_rd && (int'(r_id) == gb);
            assign w_sel_lvl[gb] = 1'b0;
        end
        for (gp = 0; gp < ihft_pkg::NUM_PADS; gp++) begin : g_pad
            for (gd = 0; gd < ihft_pkg::NUM_DIRECTIONS; gd++) begin : g_dir
                localparam int C = ihft_pkg::DIR_BASE + gp * ihft_pkg::NUM_DIRECTIONS + gd;
                assign w_hit[C]     = w_dir_wr && (int'(r_id) == gd) && (int'(r_pad) == gp);
                assign w_sel_cnt[C] = w_dir_rd && (int'(r_id) == gd) && (int'(r_pad) == gp);
                assign w_sel_lvl[C] = 1'b0;
            end
        end
        for (ga = 0; ga < ihft_pkg::NUM_AXES; ga++) begin : g_axis
            localparam int C = ihft_pkg::AXIS_BASE + ga;
            assign w_hit[C]     = w_cmd.sample && (int'(r_id) == ga);
            assign w_sel_cnt[C] = w_axis_rd && (int'(r_id) == ga);
            assign w_sel_lvl[C] = (int'(r_id) == ga);
        end
        for (gb = 0; gb < ihft_pkg::NUM_CELLS; gb++) begin : g_cell
            ihft_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_cmd     (w_cmd),
                .i_hit     (w_hit[gb]),
                .i_sel_cnt (w_sel_cnt[gb]),
                .i_sel_lvl (w_sel_lvl[gb]),
                .i_link    (w_link[gb]),
                .o_link    (w_link[gb+1])
            );
        end
    endgenerate

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_UPD;
                end
            end
            ST_UPD: begin
                n_step  = '0;
                n_state = ST_RUN;
            end
            ST_RUN: begin
                if (r_step != ihft_pkg::STEP_W'(ihft_pkg::NUM_CELLS)) begin
                    n_step = r_step + 1'b1;
                end else if (w_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid  = r_out_valid;
        n_btn_dn     = r_btn_dn;
        n_btn_up     = r_btn_up;
        n_axis_dn    = r_axis_dn;
        n_axis_up    = r_axis_up;
        n_dir_dn     = r_dir_dn;
        n_dir_up     = r_dir_up;
        n_dir_dn_pad = r_dir_dn_pad;
        n_dir_up_pad = r_dir_up_pad;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (w_load) begin
            n_out_valid = 1'b1;
            if (r_op == ihft_pkg::OP_FRAME_TICK) begin
                n_btn_dn     = '1;
                n_btn_up     = '1;
                n_axis_dn    = '1;
                n_axis_up    = '1;
                n_dir_dn     = '1;
                n_dir_up     = '1;
                n_dir_dn_pad = 1'b0;
                n_dir_up_pad = 1'b0;
            end
            if (w_btn_wr && w_btn_ok) begin
                if (r_op == ihft_pkg::OP_BTN_PRESS) begin
                    n_btn_dn = {1'b0, r_id};
                end else begin
                    n_btn_up = {1'b0, r_id};
                end
            end
            if (w_dir_wr && w_dir_ok) begin
                if (r_op == ihft_pkg::OP_DIR_PRESS) begin
                    n_dir_dn     = {1'b0, r_id[1:0]};
                    n_dir_dn_pad = r_pad;
                end else begin
                    n_dir_up     = {1'b0, r_id[1:0]};
                    n_dir_up_pad = r_pad;
                end
            end
            if (w_link[ihft_pkg::NUM_CELLS].evt_dn) begin
                n_axis_dn = {1'b0, r_id[2:0]};
            end
            if (w_link[ihft_pkg::NUM_CELLS].evt_up) begin
                n_axis_up = {1'b0, r_id[2:0]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_step       <= '0;
            r_threshold  <= ihft_pkg::t_level'(16384);
            r_out_valid  <= 1'b0;
            r_btn_dn     <= '1;
            r_btn_up     <= '1;
            r_axis_dn    <= '1;
            r_axis_up    <= '1;
            r_dir_dn     <= '1;
            r_dir_up     <= '1;
            r_dir_dn_pad <= 1'b0;
            r_dir_up_pad <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_step       <= n_step;
            r_out_valid  <= n_out_valid;
            r_btn_dn     <= n_btn_dn;
            r_btn_up     <= n_btn_up;
            r_axis_dn    <= n_axis_dn;
            r_axis_up    <= n_axis_up;
            r_dir_dn     <= n_dir_dn;
            r_dir_up     <= n_dir_up;
            r_dir_dn_pad <= n_dir_dn_pad;
            r_dir_up_pad <= n_dir_up_pad;
            if (i_cfg_we) begin
                r_threshold <= i_cfg_data;
            end
        end
    end

    // request and result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op     <= i_op;
            r_id     <= i_entry_id;
            r_pad    <= i_pad_select;
            r_sample <= i_axis_sample;
        end
        if (w_load) begin
            r_frame_count <= w_link[ihft_pkg::NUM_CELLS].count;
            r_axis_level  <= w_link[ihft_pkg::NUM_CELLS].level;
        end
    end

    assign o_in_ready          = (r_state == ST_IDLE);
    assign o_out_valid         = r_out_valid;
    assign o_frame_count       = r_frame_count;
    assign o_axis_level        = r_axis_level;
    assign o_last_button_down  = r_btn_dn;
    assign o_last_button_up    = r_btn_up;
    assign o_last_axis_down    = r_axis_dn;
    assign o_last_axis_up      = r_axis_up;
    assign o_last_dir_down     = r_dir_dn;
    assign o_last_dir_down_pad = r_dir_dn_pad;
    assign o_last_dir_up       = r_dir_up;
    assign o_last_dir_up_pad   = r_dir_up_pad;

    a_accept_starts_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_UPD))
        else $error("accepted request did not start a cell update");

    a_result_after_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == ST_RUN))
        else $error("result appeared without a chain pass");

    a_tick_count_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && r_op == ihft_pkg::OP_FRAME_TICK) |=> (o_frame_count == '0))
        else $error("frame tick returned a nonzero count");

    a_tick_clears_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && r_op == ihft_pkg::OP_FRAME_TICK)
        |=> (o_last_button_down == -6'sd1 && o_last_axis_up == -4'sd1
             && o_last_dir_down_pad == 1'b0))
        else $error("frame tick left a last-event register set");

    a_axis_event_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> !(w_link[ihft_pkg::NUM_CELLS].evt_dn && w_link[ihft_pkg::NUM_CELLS].evt_up))
        else $error("axis pressed and released in one request");

endmodule

// ===== tb/tb_input_hold_frame_tracker_unit.sv =====
`timescale 1ns / 1ps

module tb_input_hold_frame_tracker_unit;
    import ihft_pkg::*;

    localparam int LAST_DOWN = 0;
    localparam int LAST_UP   = 1;

    localparam logic [OP_W-1:0] OP_UNUSED_FIRST = 4'd9;
    localparam logic [OP_W-1:0] OP_UNUSED_LAST  = 4'd15;

    localparam int RESET_CYCLES  = 11;
    localparam int IDLE_LIMIT    = 5000;
    localparam int SETTLE_CYCLES = NUM_CELLS + 10;
    localparam int LONG_HOLD     = 400;
    localparam int PHASE_ITEMS   = 300;

    typedef struct packed {
        t_count             frame_count;
        t_level             axis_level;
        logic signed [5:0]  button_down;
        logic signed [5:0]  button_up;
        logic signed [3:0]  axis_down;
        logic signed [3:0]  axis_up;
        logic signed [2:0]  dir_down;
        logic               dir_down_pad;
        logic signed [2:0]  dir_up;
        logic               dir_up_pad;
    } report_t;

    class hold_count_tracker;
        t_count  button_counts[NUM_BUTTONS];
        t_count  dir_counts[NUM_PADS][NUM_DIRECTIONS];
        t_count  axis_counts[NUM_AXES];
        t_level  axis_levels[NUM_AXES];
        t_level  threshold;
        int      button_last[2];
        int      axis_last[2];
        int      dir_last[2];
        bit      dir_last_pad[2];
        report_t pending[$];
        int      errors;

        function new();
            foreach (button_counts[i]) button_counts[i] = '0;
            foreach (dir_counts[p, d]) dir_counts[p][d] = '0;
            foreach (axis_counts[i]) begin
                axis_counts[i] = '0;
                axis_levels[i] = '0;
            end
            threshold = t_level'(16384);
            clear_last();
            errors = 0;
        endfunction

        function void clear_last();
            for (int k = 0; k < 2; k++) begin
                button_last[k]  = -1;
                axis_last[k]    = -1;
                dir_last[k]     = -1;
                dir_last_pad[k] = 1'b0;
            end
        endfunction

        // one frame further from zero, saturating
        function t_count advanced(t_count c);
            if (c > 0 && c < CNT_MAX) return c + CNT_ONE;
            if (c < 0 && c > CNT_MIN) return c - CNT_ONE;
            return c;
        endfunction

        function void note_request(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                                   logic [PAD_W-1:0] pad, t_level sample);
            int      idx;
            int      pidx;
            bit      btn_ok;
            bit      axis_ok;
            bit      dir_ok;
            t_count  cnt;
            report_t r;
            idx     = id;
            pidx    = pad;
            btn_ok  = idx < NUM_BUTTONS;
            axis_ok = idx < NUM_AXES;
            dir_ok  = idx < NUM_DIRECTIONS && pidx < NUM_PADS;
            cnt     = '0;
            case (op)
                OP_BTN_PRESS, OP_BTN_RELEASE: begin
                    if (btn_ok) begin
                        if (op == OP_BTN_PRESS) begin
                            button_counts[idx]     = CNT_ONE;
                            button_last[LAST_DOWN] = idx;
                        end else begin
                            button_counts[idx]   = CNT_NEG_ONE;
                            button_last[LAST_UP] = idx;
                        end
                    end
                end
                OP_DIR_PRESS, OP_DIR_RELEASE: begin
                    if (dir_ok) begin
                        if (op == OP_DIR_PRESS) begin
                            dir_counts[pidx][idx]   = CNT_ONE;
                            dir_last[LAST_DOWN]     = idx;
                            dir_last_pad[LAST_DOWN] = pad;
                        end else begin
                            dir_counts[pidx][idx] = CNT_NEG_ONE;
                            dir_last[LAST_UP]     = idx;
                            dir_last_pad[LAST_UP] = pad;
                        end
                    end
                end
                OP_AXIS_SAMPLE: begin
                    if (axis_ok) begin
                        axis_levels[idx] = sample;
                        if (sample > threshold && axis_counts[idx] <= 0) begin
                            axis_counts[idx]     = CNT_ONE;
                            axis_last[LAST_DOWN] = idx;
                        end else if (sample < threshold && axis_counts[idx] > 0) begin
                            axis_counts[idx]   = CNT_NEG_ONE;
                            axis_last[LAST_UP] = idx;
                        end
                    end
                end
                OP_FRAME_TICK: begin
                    foreach (button_counts[i]) button_counts[i] = advanced(button_counts[i]);
                    foreach (axis_counts[i]) axis_counts[i] = advanced(axis_counts[i]);
                    foreach (dir_counts[p, d]) dir_counts[p][d] = advanced(dir_counts[p][d]);
                    clear_last();
                end
                default: ;
            endcase

            if ((op == OP_BTN_PRESS || op == OP_BTN_RELEASE || op == OP_READ_BTN) && btn_ok)
                cnt = button_counts[idx];
            else if ((op == OP_DIR_PRESS || op == OP_DIR_RELEASE || op == OP_READ_DIR) && dir_ok)
                cnt = dir_counts[pidx][idx];
            else if ((op == OP_AXIS_SAMPLE || op == OP_READ_AXIS) && axis_ok)
                cnt = axis_counts[idx];

            r.frame_count  = cnt;
            r.axis_level   = axis_ok ? axis_levels[idx] : '0;
            r.button_down  = 6'(button_last[LAST_DOWN]);
            r.button_up    = 6'(button_last[LAST_UP]);
            r.axis_down    = 4'(axis_last[LAST_DOWN]);
            r.axis_up      = 4'(axis_last[LAST_UP]);
            r.dir_down     = 3'(dir_last[LAST_DOWN]);
            r.dir_down_pad = dir_last_pad[LAST_DOWN];
            r.dir_up       = 3'(dir_last[LAST_UP]);
            r.dir_up_pad   = dir_last_pad[LAST_UP];
            pending.push_back(r);
        endfunction

        function void compare_field(string name, logic signed [31:0] want,
                                    logic signed [31:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            end
        endfunction

        function void check_report(report_t got);
            report_t want;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: unrequested result, count %0d level %0d",
                         $time, got.frame_count, got.axis_level);
                return;
            end
            want = pending.pop_front();
            compare_field("frame_count", want.frame_count, got.frame_count);
            compare_field("axis_level", want.axis_level, got.axis_level);
            compare_field("last_button_down", want.button_down, got.button_down);
            compare_field("last_button_up", want.button_up, got.button_up);
            compare_field("last_axis_down", want.axis_down, got.axis_down);
            compare_field("last_axis_up", want.axis_up, got.axis_up);
            compare_field("last_dir_down", want.dir_down, got.dir_down);
            compare_field("last_dir_down_pad", want.dir_down_pad, got.dir_down_pad);
            compare_field("last_dir_up", want.dir_up, got.dir_up);
            compare_field("last_dir_up_pad", want.dir_up_pad, got.dir_up_pad);
        endfunction
    endclass

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic signed [LEVEL_W-1:0] i_cfg_data;
    logic                      i_in_valid;
    logic                      o_in_ready;
    logic [OP_W-1:0]           i_op;
    logic [ID_W-1:0]           i_entry_id;
    logic [PAD_W-1:0]          i_pad_select;
    logic signed [LEVEL_W-1:0] i_axis_sample;
    logic                      o_out_valid;
    logic                      i_out_ready;
    t_count                    o_frame_count;
    t_level                    o_axis_level;
    logic signed [5:0]         o_last_button_down;
    logic signed [5:0]         o_last_button_up;
    logic signed [3:0]         o_last_axis_down;
    logic signed [3:0]         o_last_axis_up;
    logic signed [2:0]         o_last_dir_down;
    logic                      o_last_dir_down_pad;
    logic signed [2:0]         o_last_dir_up;
    logic                      o_last_dir_up_pad;

    hold_count_tracker tracker = new();

    bit hold_sink     = 1'b0;
    int sink_idle_pct = 0;
    int src_idle_pct  = 0;

    input_hold_frame_tracker_unit u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_data          (i_cfg_data),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_op                (i_op),
        .i_entry_id          (i_entry_id),
        .i_pad_select        (i_pad_select),
        .i_axis_sample       (i_axis_sample),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_frame_count       (o_frame_count),
        .o_axis_level        (o_axis_level),
        .o_last_button_down  (o_last_button_down),
        .o_last_button_up    (o_last_button_up),
        .o_last_axis_down    (o_last_axis_down),
        .o_last_axis_up      (o_last_axis_up),
        .o_last_dir_down     (o_last_dir_down),
        .o_last_dir_down_pad (o_last_dir_down_pad),
        .o_last_dir_up       (o_last_dir_up),
        .o_last_dir_up_pad   (o_last_dir_up_pad)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 20);
        return $urandom_range(40, 150);
    endfunction

    // samples cluster around the threshold so presses and releases both happen
    function automatic t_level pick_sample();
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 30) return t_level'($urandom);
        if (r < 45) return tracker.threshold;
        if (r < 70) begin
            v = tracker.threshold + int'($urandom_range(0, 6)) - 3;
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            return t_level'(v);
        end
        if (r < 85) return $urandom_range(0, 1) ? t_level'(32767) : t_level'(-32768);
        return '0;
    endfunction

    task automatic send_request(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                                input logic [PAD_W-1:0] pad, input t_level sample);
        i_in_valid    <= 1'b1;
        i_op          <= op;
        i_entry_id    <= id;
        i_pad_select  <= pad;
        i_axis_sample <= sample;
        do @(posedge i_clk); while (!o_in_ready);
        tracker.note_request(op, id, pad, sample);
    endtask

    task automatic pause_source(input int n);
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_threshold(input t_level v);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        tracker.threshold = v;
    endtask

    task automatic send_random_request(output bit useful);
        logic [OP_W-1:0]  op;
        logic [ID_W-1:0]  id;
        logic [PAD_W-1:0] pad;
        int               r;
        int               span;
        r = $urandom_range(0, 99);
        if (r < 12)      op = OP_BTN_PRESS;
        else if (r < 22) op = OP_BTN_RELEASE;
        else if (r < 30) op = OP_DIR_PRESS;
        else if (r < 37) op = OP_DIR_RELEASE;
        else if (r < 57) op = OP_AXIS_SAMPLE;
        else if (r < 70) op = OP_FRAME_TICK;
        else if (r < 78) op = OP_READ_BTN;
        else if (r < 85) op = OP_READ_DIR;
        else if (r < 93) op = OP_READ_AXIS;
        else             op = OP_W'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
        case (op)
            OP_DIR_PRESS, OP_DIR_RELEASE, OP_READ_DIR: span = NUM_DIRECTIONS;
            OP_AXIS_SAMPLE, OP_READ_AXIS:              span = NUM_AXES;
            default:                                   span = NUM_BUTTONS;
        endcase
        if ($urandom_range(0, 99) < 85) id = ID_W'($urandom_range(0, span - 1));
        else id = ID_W'($urandom);
        pad = PAD_W'($urandom);
        useful = op < OP_UNUSED_FIRST && (op == OP_FRAME_TICK || int'(id) < span);
        send_request(op, id, pad, pick_sample());
    endtask

    initial begin : sink
        report_t got;
        int      idle_left;
        bit      rdy;
        i_out_ready <= 1'b0;
        idle_left = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        forever begin
            if (hold_sink) begin
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_sink = 1'b0;
            end else begin
                if (idle_left > 0) begin
                    rdy = 1'b0;
                    idle_left--;
                end else if ($urandom_range(0, 99) < sink_idle_pct) begin
                    rdy = 1'b0;
                    idle_left = pick_gap() - 1;
                end else begin
                    rdy = 1'b1;
                end
                i_out_ready <= rdy;
                @(posedge i_clk);
                if (o_out_valid && i_out_ready) begin
                    got.frame_count  = o_frame_count;
                    got.axis_level   = o_axis_level;
                    got.button_down  = o_last_button_down;
                    got.button_up    = o_last_button_up;
                    got.axis_down    = o_last_axis_down;
                    got.axis_up      = o_last_axis_up;
                    got.dir_down     = o_last_dir_down;
                    got.dir_down_pad = o_last_dir_down_pad;
                    got.dir_up       = o_last_dir_up;
                    got.dir_up_pad   = o_last_dir_up_pad;
                    tracker.check_report(got);
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        int quiet;
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= IDLE_LIMIT) begin
                $display("%0t: no request moved for %0d cycles", $time, IDLE_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin : stimulus
        t_level thresholds[4];
        int     counted;
        int     n;
        bit     useful;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_data    <= '0;
        i_in_valid    <= 1'b0;
        i_op          <= OP_READ_BTN;
        i_entry_id    <= '0;
        i_pad_select  <= '0;
        i_axis_sample <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, reset threshold
        send_request(OP_READ_BTN, 0, 0, 0);
        send_request(OP_BTN_PRESS, 0, 0, 0);
        send_request(OP_BTN_PRESS, 31, 1, -1);
        send_request(OP_BTN_RELEASE, 31, 0, 0);
        send_request(OP_BTN_RELEASE, 31, 0, 0);
        send_request(OP_BTN_PRESS, 0, 0, 0);
        send_request(OP_DIR_PRESS, 3, 1, 0);
        send_request(OP_DIR_RELEASE, 0, 0, 0);
        send_request(OP_DIR_PRESS, 4, 1, 0);
        send_request(OP_AXIS_SAMPLE, 7, 0, 32767);
        send_request(OP_AXIS_SAMPLE, 7, 0, 16384);
        send_request(OP_AXIS_SAMPLE, 0, 0, 16384);
        send_request(OP_AXIS_SAMPLE, 7, 1, -32768);
        send_request(OP_AXIS_SAMPLE, 31, 0, 21845);
        send_request(OP_FRAME_TICK, 0, 0, 0);
        send_request(OP_READ_BTN, 0, 0, 0);
        send_request(OP_READ_BTN, 31, 0, 0);
        send_request(OP_READ_DIR, 3, 1, 0);
        send_request(OP_READ_DIR, 31, 0, 0);
        send_request(OP_READ_AXIS, 7, 0, 0);
        send_request(OP_READ_AXIS, 8, 0, 0);
        send_request(OP_FRAME_TICK, 5, 1, 0);
        send_request(OP_UNUSED_FIRST, 0, 0, 0);
        send_request(OP_UNUSED_LAST, 31, 1, 32767);
        send_request(OP_READ_DIR, 0, 0, 0);

        thresholds[0] = -32768;
        thresholds[1] = 32767;
        thresholds[2] = t_level'($urandom);
        thresholds[3] = 16384;

        for (int phase = 0; phase < 4; phase++) begin
            write_threshold(thresholds[phase]);
            case (phase)
                0: begin src_idle_pct = 0;  sink_idle_pct = 0;  end
                1: begin src_idle_pct = 20; sink_idle_pct = 20; end
                2: begin src_idle_pct = 10; sink_idle_pct = 50; end
                default: begin src_idle_pct = 50; sink_idle_pct = 10; end
            endcase
            // long output stall while requests keep coming
            if (phase == 1) hold_sink = 1'b1;
            counted = 0;
            n = 0;
            while (counted < PHASE_ITEMS) begin
                if (phase == 2 && n == PHASE_ITEMS / 2) drain();
                if ($urandom_range(0, 99) < src_idle_pct) pause_source(pick_gap());
                send_random_request(useful);
                if (useful) counted++;
                n++;
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.pending.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/ihft_pkg.sv
rtl/ihft_cell.sv
rtl/input_hold_frame_tracker_unit.sv
tb/tb_input_hold_frame_tracker_unit.sv
